// ----- design/sfla_pkg.sv -----
`default_nettype none
package sfla_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_INVAL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LATCH    = 4'd1,
    OP_RD_HEAD  = 4'd2,
    OP_CLASS    = 4'd3,
    OP_WALK_RD  = 4'd4,
    OP_WALK_EV  = 4'd5,
    OP_GRANT    = 4'd6,
    OP_BUMP     = 4'd7,
    OP_FREE_RD  = 4'd8,
    OP_FREE_EV  = 4'd9,
    OP_SPLIT    = 4'd10,
    OP_UNLINK   = 4'd11
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic is_class;
    logic head_valid;
    logic walk_fit;
    logic walk_end;
    logic do_split;
  } sts_t;

endpackage
`default_nettype wire

// ----- design/segregated_free_list_allocator.sv -----
// operation: a free reads the header and pushes the block on its list; a class allocate
// bumps if its list is empty, else pops the head; a large allocate walks the large list,
// one header read per node, then splits if roomy and unlinks a fit, or bumps at the end
// throughput: one word at a time, ready for the next word in the cycle after the result is taken
// reset: asynchronous active low, clears the list heads and bump pointer, sets the limit
// to 65536 and resets control; header memory is not cleared and needs no clearing pass
`default_nettype none
module segregated_free_list_allocator #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 16,
  parameter int SIZE_CLASSES = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // request_size, free_offset
  input  wire logic        s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // payload_offset, granted_size, status, pad
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i
);

  sfla_pkg::cmd_t cmd;
  sfla_pkg::sts_t sts;
  logic [15:0] r_off, r_size;
  logic [1:0]  r_st;

  sfla_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  sfla_datapath #(
    .HeapBytes(HEAP_BYTES), .HeaderBytes(HEADER_BYTES), .SizeClasses(SIZE_CLASSES)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .s_action_i(s_axis_tuser), .s_size_i(s_axis_tdata[15:0]),
    .s_off_i(s_axis_tdata[31:16]),
    .cfg_we_i, .cfg_wdata_i,
    .res_off_o(r_off), .res_size_o(r_size), .res_status_o(r_st)
  );

  assign m_axis_tdata = {6'd0, r_st, r_size, r_off};

endmodule
`default_nettype wire

// ----- design/sfla_datapath.sv -----
`default_nettype none
module sfla_datapath #(
  parameter int HeapBytes   = 65536,
  parameter int HeaderBytes = 16,
  parameter int SizeClasses = 6
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sfla_pkg::cmd_t      cmd_i,
  output sfla_pkg::sts_t           sts_o,
  input  wire logic                s_action_i,
  input  wire logic [15:0]         s_size_i,
  input  wire logic [15:0]         s_off_i,
  input  wire logic                cfg_we_i,
  input  wire logic [16:0]         cfg_wdata_i,
  output logic [15:0]              res_off_o,
  output logic [15:0]              res_size_o,
  output logic [1:0]               res_status_o
);

  localparam int AW = $clog2(HeapBytes);
  localparam int PW = AW + 1;
  localparam int NumClasses = (SizeClasses < 1) ? 1 : ((SizeClasses > 6) ? 6 : SizeClasses);
  localparam int LargeList = 6;
  localparam logic [PW-1:0] Nil = PW'(HeapBytes);
  localparam logic [PW:0] HdrW = (PW+1)'(HeaderBytes);

  logic [PW-1:0] mem_next [HeapBytes];
  logic [PW-1:0] mem_size [HeapBytes];

  logic [16:0]   limit_q;
  logic [PW-1:0] top_q;
  logic [PW-1:0] heads_q [7];
  logic          act_q;
  logic [15:0]   req_q;
  logic [15:0]   off_q;
  logic [2:0]    list_q;
  logic          isclass_q;
  logic [PW-1:0] csize_q;
  logic [PW-1:0] h_q, prev_q;
  logic [PW-1:0] rd_next_q, rd_size_q;
  logic [PW-1:0] steps_q;

  logic [2:0]    cls_idx;
  logic          cls_hit;
  logic [PW-1:0] cls_bytes;
  logic [PW-1:0] eff_lim;
  logic [PW+1:0] bump_end;
  logic [PW-1:0] bump_sz;
  logic [PW:0]   twice;
  logic [PW+1:0] rem_addr;
  logic          split_ok;
  logic [16:0]   fh;
  logic [2:0]    f_list;
  logic          f_bad;

  function automatic logic [9:0] class_of(input int c);
    return 10'(16 << c);
  endfunction

  always_comb begin
    cls_idx = 3'd0;
    cls_hit = 1'b0;
    for (int c = NumClasses - 1; c >= 0; c--) begin
      if (17'(req_q) <= 17'(class_of(c))) begin
        cls_idx = 3'(c);
        cls_hit = 1'b1;
      end
    end
    cls_bytes = PW'(class_of(int'(cls_idx)));
  end

  assign eff_lim  = (32'(limit_q) > 32'(HeapBytes)) ? Nil : PW'(limit_q);
  assign bump_sz  = isclass_q ? csize_q : PW'(req_q);
  assign bump_end = (PW+2)'(top_q) + (PW+2)'(HdrW) + (PW+2)'(bump_sz);
  assign twice    = (PW+1)'(req_q) << 1;
  assign rem_addr = (PW+2)'(h_q) + (PW+2)'(HdrW) + (PW+2)'(twice);
  assign split_ok = ((PW+2)'(rd_size_q) > (PW+2)'(twice) + (PW+2)'(HdrW))
                    && (rem_addr < (PW+2)'(HeapBytes));

  assign fh = 17'(off_q) - 17'(HeaderBytes);

  always_comb begin
    f_list = 3'd7;
    for (int c = 0; c < NumClasses; c++) begin
      if (rd_size_q == PW'(class_of(c))) f_list = 3'(c);
    end
    if (f_list == 3'd7 && rd_size_q > PW'(class_of(NumClasses - 1))) f_list = 3'(LargeList);
    f_bad = (f_list == 3'd7);
  end

  assign sts_o.is_free    = act_q;
  assign sts_o.is_class   = isclass_q;
  assign sts_o.head_valid = (h_q < Nil);
  assign sts_o.walk_fit   = (rd_size_q >= PW'(req_q));
  assign sts_o.walk_end   = !(h_q < Nil) || (steps_q >= PW'(HeapBytes));
  assign sts_o.do_split   = split_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 17'(65536);
      top_q   <= '0;
      for (int i = 0; i < 7; i++) heads_q[i] <= Nil;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      unique case (cmd_i.op)
        sfla_pkg::OP_CLASS: begin
          heads_q[list_q] <= rd_next_q;
        end
        sfla_pkg::OP_BUMP: begin
          if (!(bump_end > (PW+2)'(eff_lim)) && top_q < Nil) top_q <= PW'(bump_end);
        end
        sfla_pkg::OP_UNLINK: begin
          if (!(prev_q < Nil)) heads_q[LargeList] <= rd_next_q;
        end
        sfla_pkg::OP_FREE_EV: begin
          if (!(off_q < 16'(HeaderBytes)) && !f_bad) heads_q[f_list] <= h_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      sfla_pkg::OP_LATCH: begin
        act_q   <= s_action_i;
        req_q   <= s_size_i;
        off_q   <= s_off_i;
        steps_q <= '0;
        prev_q  <= Nil;
      end
      sfla_pkg::OP_RD_HEAD: begin
        isclass_q <= cls_hit;
        csize_q   <= cls_bytes;
        list_q    <= cls_hit ? cls_idx : 3'(LargeList);
        h_q       <= cls_hit ? heads_q[cls_idx] : heads_q[LargeList];
      end
      sfla_pkg::OP_WALK_RD, sfla_pkg::OP_FREE_RD: begin
        if (cmd_i.op == sfla_pkg::OP_FREE_RD) h_q <= PW'(fh);
        if (cmd_i.op == sfla_pkg::OP_FREE_RD) begin
          rd_size_q <= mem_size[fh[AW-1:0]];
        end else begin
          rd_size_q <= mem_size[h_q[AW-1:0]];
          rd_next_q <= mem_next[h_q[AW-1:0]];
        end
      end
      sfla_pkg::OP_WALK_EV: begin
        prev_q  <= h_q;
        h_q     <= rd_next_q;
        steps_q <= steps_q + PW'(1);
      end
      sfla_pkg::OP_SPLIT: begin
        mem_next[rem_addr[AW-1:0]] <= rd_next_q;
        mem_size[rem_addr[AW-1:0]] <= PW'((PW+2)'(rd_size_q) - (PW+2)'(twice)
                                        - (PW+2)'(HdrW));
        mem_next[h_q[AW-1:0]]      <= PW'(rem_addr);
        mem_size[h_q[AW-1:0]]      <= PW'(twice);
        rd_next_q <= PW'(rem_addr);
        rd_size_q <= PW'(twice);
      end
      sfla_pkg::OP_UNLINK: begin
        if (prev_q < Nil) mem_next[prev_q[AW-1:0]] <= rd_next_q;
      end
      sfla_pkg::OP_FREE_EV: begin
        if (!(off_q < 16'(HeaderBytes)) && !f_bad) mem_next[h_q[AW-1:0]] <= heads_q[f_list];
      end
      sfla_pkg::OP_BUMP: begin
        if (!(bump_end > (PW+2)'(eff_lim)) && top_q < Nil) mem_size[top_q[AW-1:0]] <= bump_sz;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      sfla_pkg::OP_CLASS, sfla_pkg::OP_GRANT: begin
        res_off_o    <= 16'((PW+1)'(h_q) + HdrW);
        res_size_o   <= 16'(rd_size_q);
        res_status_o <= sfla_pkg::ST_OK;
      end
      sfla_pkg::OP_BUMP: begin
        if (bump_end > (PW+2)'(eff_lim) || !(top_q < Nil)) begin
          res_off_o    <= '0;
          res_size_o   <= '0;
          res_status_o <= sfla_pkg::ST_OOM;
        end else begin
          res_off_o    <= 16'((PW+1)'(top_q) + HdrW);
          res_size_o   <= 16'(bump_sz);
          res_status_o <= sfla_pkg::ST_OK;
        end
      end
      sfla_pkg::OP_FREE_EV: begin
        res_off_o    <= '0;
        res_size_o   <= '0;
        res_status_o <= ((off_q < 16'(HeaderBytes)) || f_bad) ? sfla_pkg::ST_INVAL
                                                              : sfla_pkg::ST_OK;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/sfla_ctrl.sv -----
`default_nettype none
module sfla_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  wire logic           m_ready_i,
  input  wire sfla_pkg::sts_t sts_i,
  output sfla_pkg::cmd_t      cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_DEC     = 11'b00000000010,
    S_HRD     = 11'b00000000100,
    S_HEV     = 11'b00000001000,
    S_WRD     = 11'b00000010000,
    S_WEV     = 11'b00000100000,
    S_SPLIT   = 11'b00001000000,
    S_UNLINK  = 11'b00010000000,
    S_BUMP    = 11'b00100000000,
    S_FRD     = 11'b01000000000,
    S_OUT     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = sfla_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.op = sfla_pkg::OP_LATCH;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.is_free) begin
          cmd_o.op = sfla_pkg::OP_FREE_RD;
          state_d  = S_FRD;
        end else begin
          cmd_o.op = sfla_pkg::OP_RD_HEAD;
          state_d  = S_HRD;
        end
      end
      S_HRD: begin
        if (sts_i.is_class && !sts_i.head_valid) begin
          cmd_o.op = sfla_pkg::OP_BUMP;
          state_d  = S_OUT;
        end else if (sts_i.is_class) begin
          cmd_o.op = sfla_pkg::OP_WALK_RD;
          state_d  = S_HEV;
        end else if (sts_i.walk_end) begin
          cmd_o.op = sfla_pkg::OP_BUMP;
          state_d  = S_OUT;
        end else begin
          cmd_o.op = sfla_pkg::OP_WALK_RD;
          state_d  = S_WEV;
        end
      end
      S_HEV: begin
        cmd_o.op = sfla_pkg::OP_CLASS;
        state_d  = S_OUT;
      end
      S_WRD: begin
        if (sts_i.walk_end) begin
          cmd_o.op = sfla_pkg::OP_BUMP;
          state_d  = S_OUT;
        end else begin
          cmd_o.op = sfla_pkg::OP_WALK_RD;
          state_d  = S_WEV;
        end
      end
      S_WEV: begin
        if (sts_i.walk_fit) begin
          if (sts_i.do_split) begin
            cmd_o.op = sfla_pkg::OP_SPLIT;
            state_d  = S_SPLIT;
          end else begin
            cmd_o.op = sfla_pkg::OP_UNLINK;
            state_d  = S_UNLINK;
          end
        end else begin
          cmd_o.op = sfla_pkg::OP_WALK_EV;
          state_d  = S_WRD;
        end
      end
      S_SPLIT: begin
        cmd_o.op = sfla_pkg::OP_UNLINK;
        state_d  = S_UNLINK;
      end
      S_UNLINK: begin
        cmd_o.op = sfla_pkg::OP_GRANT;
        state_d  = S_OUT;
      end
      S_BUMP: begin
        state_d = S_OUT;
      end
      S_FRD: begin
        cmd_o.op = sfla_pkg::OP_FREE_EV;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (m_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/sfla_checker.sv -----
`default_nettype none
module sfla_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("accept while result pending");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3) else $error("bad status");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[33:32] != 2'd0) |-> m_axis_tdata[15:0] == 16'd0)
    else $error("failed result carries offset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

endmodule

bind segregated_free_list_allocator sfla_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

// ----- sim/segregated_free_list_allocator_test.sv -----
`timescale 1ns / 1ps
module segregated_free_list_allocator_test;

  localparam int unsigned HEAP = 65536;
  localparam int unsigned HDR = 16;
  localparam int unsigned NIL = HEAP;
  localparam int unsigned LARGE = 6;
  localparam int unsigned WATCHDOG_LIMIT = 400000;
  localparam int unsigned CLS[6] = '{16, 32, 64, 128, 256, 512};

  typedef enum logic [1:0] {K_WORD, K_HOLD, K_CFG} kind_e;
  typedef struct {
    kind_e       kind;
    logic [39:0] word;
    logic [16:0] cfg;
  } plan_t;
  typedef struct {
    logic [15:0]       pay;
    logic [15:0]       gsz;
    sfla_pkg::status_e st;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;

  always #2 clk_i = ~clk_i;

  segregated_free_list_allocator uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i
  );

  // allocator shadow state
  int unsigned heap_next[HEAP];
  int unsigned heap_size[HEAP];
  int unsigned bump_ptr;
  int unsigned list_head[7];
  int unsigned limit_reg;

  plan_t  plan_q[$];
  grant_t grant_q[$];
  int unsigned live_q[$];
  int unsigned freed_cls_q[$];

  int n_sent = 0;
  int n_got = 0;
  int mismatches = 0;

  function automatic int unsigned bump_alloc(int unsigned sz);
    int unsigned top, fin, lim;
    top = bump_ptr;
    fin = top + HDR + sz;
    lim = (limit_reg > HEAP) ? HEAP : limit_reg;
    if (fin > lim || top >= HEAP) return NIL;
    bump_ptr = fin;
    heap_size[top] = sz;
    return top;
  endfunction

  function automatic void add_grant(int unsigned h, int unsigned sz, sfla_pkg::status_e st);
    grant_t g;
    g.pay = (h == NIL) ? 16'd0 : 16'(h + HDR);
    g.gsz = 16'(sz);
    g.st = st;
    grant_q.push_back(g);
    if (st == sfla_pkg::ST_OK) live_q.push_back(h + HDR);
  endfunction

  function automatic void push_alloc(int unsigned req);
    plan_t p;
    int unsigned h, prv, steps, twice, rem;
    p.kind = K_WORD;
    p.cfg = '0;
    p.word = {7'd0, 16'($urandom), 16'(req), 1'b0};
    plan_q.push_back(p);
    for (int c = 0; c < 6; c++) begin
      if (req <= CLS[c]) begin
        h = list_head[c];
        if (h < HEAP) begin
          list_head[c] = heap_next[h];
          add_grant(h, heap_size[h], sfla_pkg::ST_OK);
        end else begin
          h = bump_alloc(CLS[c]);
          if (h == NIL) add_grant(NIL, 0, sfla_pkg::ST_OOM);
          else add_grant(h, CLS[c], sfla_pkg::ST_OK);
        end
        return;
      end
    end
    prv = NIL;
    h = list_head[LARGE];
    for (steps = 0; h < HEAP && steps < HEAP; steps++) begin
      if (heap_size[h] >= req) begin
        twice = 2 * req;
        if (heap_size[h] > twice + HDR) begin
          rem = h + HDR + twice;
          if (rem < HEAP) begin
            heap_next[rem] = heap_next[h];
            heap_size[rem] = heap_size[h] - twice - HDR;
            heap_next[h] = rem;
            heap_size[h] = twice;
          end
        end
        if (prv < HEAP) heap_next[prv] = heap_next[h];
        else list_head[LARGE] = heap_next[h];
        add_grant(h, heap_size[h], sfla_pkg::ST_OK);
        return;
      end
      prv = h;
      h = heap_next[h];
    end
    h = bump_alloc(req);
    if (h == NIL) add_grant(NIL, 0, sfla_pkg::ST_OOM);
    else add_grant(h, req, sfla_pkg::ST_OK);
  endfunction

  function automatic void push_free(int unsigned off);
    plan_t p;
    grant_t g;
    int unsigned h, sz, lst;
    p.kind = K_WORD;
    p.cfg = '0;
    p.word = {7'd0, 16'(off), 16'($urandom), 1'b1};
    plan_q.push_back(p);
    g.pay = '0;
    g.gsz = '0;
    g.st = sfla_pkg::ST_INVAL;
    if (off >= HDR) begin
      h = off - HDR;
      sz = heap_size[h];
      lst = 7;
      for (int c = 0; c < 6; c++) if (sz == CLS[c]) lst = c;
      if (lst == 7 && sz > CLS[5]) lst = LARGE;
      if (lst != 7) begin
        heap_next[h] = list_head[lst];
        list_head[lst] = h;
        g.st = sfla_pkg::ST_OK;
        if (lst != LARGE) freed_cls_q.push_back(off);
      end
    end
    grant_q.push_back(g);
  endfunction

  function automatic void free_live(int unsigned k);
    int unsigned off;
    off = live_q[k];
    live_q.delete(k);
    push_free(off);
  endfunction

  function automatic void push_marker(kind_e k, logic [16:0] v);
    plan_t p;
    p.kind = k;
    p.word = '0;
    p.cfg = v;
    plan_q.push_back(p);
    if (k == K_CFG) limit_reg = v;
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 512);
    if (r < 95) return $urandom_range(513, 2048);
    return $urandom_range(0, 65535);
  endfunction

  function automatic void random_run(int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55 || live_q.size() == 0) begin
        push_alloc(pick_size());
      end else if (r < 90) begin
        free_live($urandom_range(0, live_q.size() - 1));
      end else if (r < 95 && freed_cls_q.size() != 0) begin
        push_free(freed_cls_q[$urandom_range(0, freed_cls_q.size() - 1)]);
      end else begin
        push_free($urandom_range(0, HDR - 1));
      end
    end
  endfunction

  // driver
  int burst_left = 0;
  int gap_left = 0;
  int quiet = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      bit take;
      bit we;
      take = s_axis_tvalid && s_axis_tready;
      we = 1'b0;
      if (take) n_sent <= n_sent + 1;
      quiet = (n_sent == n_got && !s_axis_tvalid) ? quiet + 1 : 0;
      if (s_axis_tvalid && !take) begin
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (plan_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        case (plan_q[0].kind)
          K_WORD: begin
            s_axis_tdata <= plan_q[0].word[32:1];
            s_axis_tuser <= plan_q[0].word[0];
            s_axis_tvalid <= 1'b1;
            void'(plan_q.pop_front());
            if (burst_left > 0) burst_left--;
            else begin
              burst_left = $urandom_range(0, 24);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
          end
          K_HOLD: begin
            s_axis_tvalid <= 1'b0;
            if (!take && n_sent == n_got) void'(plan_q.pop_front());
          end
          default: begin
            s_axis_tvalid <= 1'b0;
            if (!take && quiet >= 12) begin
              we = 1'b1;
              cfg_wdata_i <= plan_q[0].cfg;
              void'(plan_q.pop_front());
            end
          end
        endcase
      end
      cfg_we_i <= we;
    end
  end

  // receiver stall pattern
  int unsigned cyc = 0;
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc[9]) m_axis_tready <= 1'b1;
    else if (cyc[6]) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= ($urandom_range(0, 1) != 0);
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      grant_t g;
      n_got <= n_got + 1;
      if (n_got >= n_sent || grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        g = grant_q.pop_front();
        if (m_axis_tdata[15:0] !== g.pay || m_axis_tdata[31:16] !== g.gsz ||
            m_axis_tdata[33:32] !== g.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected off %h size %h st %0d, got off %h size %h st %0d",
                     n_got, g.pay, g.gsz, g.st, m_axis_tdata[15:0],
                     m_axis_tdata[31:16], m_axis_tdata[33:32]);
        end
      end
    end
  end

  // watchdog
  int unsigned idle_cyc = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned a;
    bump_ptr = 0;
    limit_reg = 65536;
    for (int i = 0; i < 7; i++) list_head[i] = NIL;
    // directed
    push_alloc(0);
    push_alloc(1);
    push_alloc(16);
    push_alloc(17);
    push_alloc(64);
    push_alloc(128);
    push_alloc(256);
    push_alloc(512);
    push_alloc(513);
    push_alloc(2000);
    a = live_q[0];
    free_live(0);
    push_free(a);
    push_alloc(5);
    push_alloc(9);
    free_live(live_q.size() - 1);
    push_alloc(700);
    push_alloc(580);
    free_live(live_q.size() - 3);
    push_alloc(600);
    push_alloc(200);
    push_free(0);
    push_free(15);
    push_alloc(65535);
    free_live(live_q.size() - 1);
    push_marker(K_HOLD, '0);
    random_run(60);
    push_marker(K_CFG, 17'd0);
    random_run(40);
    push_marker(K_CFG, 17'h1FFFF);
    random_run(150);
    push_marker(K_HOLD, '0);
    random_run(60);
    push_marker(K_CFG, 17'(bump_ptr + $urandom_range(500, 3000)));
    random_run(100);
    push_marker(K_CFG, 17'd65536);
    random_run(100);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (plan_q.size() == 0 && grant_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
